>>> rtl/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the +IPD frame parser.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int ByteW  = 8;
  localparam int LinkW  = 8;
  localparam int LenW   = 16;

  localparam logic [LenW-1:0] LimitReset = 16'd1024;

  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] ChComma = 8'h2C;  // ','
  localparam logic [ByteW-1:0] ChColon = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'

  // one result item
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [LinkW-1:0] link_number;
    logic [LenW-1:0]  frame_length;
    logic             empty_frame;
    logic             last;
  } ipd_result_t;

  // expected header text after '+'
  function automatic logic [ByteW-1:0] hdr_char(input logic [1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      2'd0:    ch = 8'h49;  // 'I'
      2'd1:    ch = 8'h50;  // 'P'
      2'd2:    ch = 8'h44;  // 'D'
      default: ch = 8'h2C;  // ','
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/ipd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_if
// Valid/ready channels of the frame parser: byte input, result output, and
// the limit register write channel.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       discard;

  modport source (output valid, rx_byte, discard, input ready);
  modport sink   (input valid, rx_byte, discard, output ready);
endinterface

interface ipd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [7:0]  link_number;
  logic [15:0] frame_length;
  logic        empty_frame;
  logic        last;

  modport source (output valid, payload_byte, link_number, frame_length, empty_frame, last,
                  input ready);
  modport sink   (input valid, payload_byte, link_number, frame_length, empty_frame, last,
                  output ready);
endinterface

interface ipd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_limit;

  modport source (output valid, payload_limit, input ready);
  modport sink   (input valid, payload_limit, output ready);
endinterface

>>> rtl/ipd_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_frame_parser
// Finds "+IPD,<link>,<length>:<payload>" frames in a received byte stream
// and emits each payload byte with its link id and clamped length.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Moves                              Accept
//  cfg      in   payload_limit write (16 b)         cfg.valid & cfg.ready
//  rx       in   rx_byte, discard                   rx.valid & rx.ready
//  frame    out  payload_byte, link_number,         frame.valid & frame.ready
//                frame_length, empty_frame, last
//
//  One byte per cycle while the skid entry is empty. A byte is parsed in the
//  cycle it is accepted; its result (if any) goes to the output register.
//  Synchronous active-high rst clears the parser to idle and the limit to 1024.
//  A stalled frame output is absorbed by a one-entry skid; rx.ready drops
//  only when that skid holds a request.
//  cfg.ready is always high; write the limit only while the parser is idle.
//
module ipd_frame_parser (
  input  logic clk,
  input  logic rst,
  ipd_cfg_if.sink   cfg,
  ipd_in_if.sink    rx,
  ipd_out_if.source frame
);
  import ipd_pkg::*;

  logic [LenW-1:0] payload_limit;

  // limit register; writes are to come only while idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LimitReset;
    end else if (cfg.valid) begin
      payload_limit <= cfg.payload_limit;
    end
  end

  logic        take;
  logic        res_valid;
  logic        skid_ready;
  ipd_result_t res;
  ipd_result_t out_data;

  assign rx.ready = skid_ready;
  assign take     = rx.valid && skid_ready;

  // parser: state registers plus one step of next-state logic
  ipd_parse_core u_core (
    .clk           (clk),
    .rst           (rst),
    .payload_limit (payload_limit),
    .take          (take),
    .rx_byte       (rx.rx_byte),
    .discard       (rx.discard),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result register + skid entry
  ipd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (skid_ready),
    .out_valid (frame.valid),
    .out_data  (out_data),
    .out_ready (frame.ready)
  );

  assign frame.payload_byte = out_data.payload_byte;
  assign frame.link_number  = out_data.link_number;
  assign frame.frame_length = out_data.frame_length;
  assign frame.empty_frame  = out_data.empty_frame;
  assign frame.last         = out_data.last;

endmodule

>>> rtl/ipd_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_parse_core
// Per-byte parser state machine; produces at most one result per byte.
// ----------------------------------------------------------------------------
module ipd_parse_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          payload_limit,
  input  logic                 take,        // byte accepted this cycle
  input  logic [7:0]           rx_byte,
  input  logic                 discard,
  output logic                 res_valid,
  output ipd_pkg::ipd_result_t res
);
  import ipd_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_LINK   = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  logic [2:0]      phase, phase_next;
  logic [1:0]      header_count, header_count_next;
  logic            header_match, header_match_next;
  logic [LinkW-1:0] link_accum, link_accum_next;
  logic [LenW-1:0]  length_accum, length_accum_next;
  logic [LenW-1:0]  payload_count, payload_count_next;

  logic            is_digit;
  logic [3:0]      digit;
  logic [LenW-1:0] count_inc;

  assign is_digit  = (rx_byte >= ChZero) && (rx_byte <= ChNine);
  assign digit     = 4'(rx_byte - ChZero);
  assign count_inc = payload_count + 16'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    header_match_next  = header_match;
    link_accum_next    = link_accum;
    length_accum_next  = length_accum;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.payload_byte   = rx_byte;
    res.link_number    = link_accum;
    res.frame_length   = length_accum;
    res.empty_frame    = 1'b0;
    res.last           = 1'b0;

    if (take && !discard) begin
      case (phase)
        PH_HEADER: begin
          if (rx_byte != hdr_char(header_count)) header_match_next = 1'b0;
          header_count_next = header_count + 2'd1;
          if (header_count == 2'd3) begin
            // all four bytes consumed, match or not
            if (header_match && rx_byte == hdr_char(header_count)) begin
              phase_next      = PH_LINK;
              link_accum_next = '0;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_LINK: begin
          if (rx_byte == ChComma) begin
            phase_next        = PH_LENGTH;
            length_accum_next = '0;
          end else if (is_digit) begin
            // x*10 + d, wraps mod 256
            link_accum_next = (link_accum << 3) + (link_accum << 1) + LinkW'(digit);
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_LENGTH: begin
          if (rx_byte == ChColon) begin
            phase_next         = PH_DATA;
            payload_count_next = '0;
            if (length_accum > payload_limit) length_accum_next = payload_limit;
          end else if (is_digit) begin
            length_accum_next = (length_accum << 3) + (length_accum << 1) + LenW'(digit);
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (length_accum == '0) begin
            res.payload_byte = '0;
            res.empty_frame  = 1'b1;
            res.last         = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            payload_count_next = count_inc;
            if (count_inc >= length_accum) begin
              res.last   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
          // idle and unused codes
          phase_next = PH_IDLE;
          if (rx_byte == ChPlus) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
            header_match_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      header_match  <= 1'b1;
      link_accum    <= '0;
      length_accum  <= '0;
      payload_count <= '0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      header_match  <= header_match_next;
      link_accum    <= link_accum_next;
      length_accum  <= length_accum_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

>>> rtl/ipd_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_out_skid
// Result register with one skid entry, so the input side keeps running
// while one result waits.
// ----------------------------------------------------------------------------
module ipd_out_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ipd_pkg::ipd_result_t in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output ipd_pkg::ipd_result_t out_data,
  input  logic                 out_ready
);
  import ipd_pkg::*;

  logic        skid_valid;
  ipd_result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipd_frame_parser. A queue-fed driver sends
// received bytes: directed frames first, then random frames, noise and
// broken frames, with discarded bytes mixed in. Each accepted byte runs
// through a software parser that forecasts the frame results. A monitor
// compares every result field by field. Both sides stall at random, and
// the payload limit is rewritten between phases while the parser is idle.
// ----------------------------------------------------------------------------
module testbench;
  import ipd_pkg::*;

  // parser phases of the forecast model
  typedef enum logic [2:0] {
    PhIdle,
    PhHeader,
    PhLink,
    PhLength,
    PhData
  } parse_phase_e;

  // ways a generated frame can be broken
  typedef enum int {
    FlawNone,
    FlawHeader,
    FlawLink,
    FlawLength,
    FlawShort
  } frame_flaw_e;

  // one byte request toward the parser
  typedef struct packed {
    logic [7:0] b;
    logic       d;
  } rx_req_t;

  // "IPD," as expected after the '+'
  localparam logic [7:0] IpdText [4] = '{8'h49, 8'h50, 8'h44, ChComma};
  localparam logic [7:0] Filler = 8'h78;  // 'x': ends any unfinished frame

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipd_cfg_if cfg_bus ();
  ipd_in_if  rx_bus ();
  ipd_out_if frame_bus ();

  ipd_frame_parser i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .rx    (rx_bus),
    .frame (frame_bus)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Forecast model state: our own copy of the parser and the limit.
  // --------------------------------------------------------------------------
  parse_phase_e ph;
  logic [2:0]   hdr_cnt;
  logic         hdr_ok;
  logic [7:0]   link_acc;
  logic [15:0]  len_acc;
  logic [15:0]  pay_cnt;
  logic [15:0]  limit_reg;

  ipd_result_t frame_expect_q[$];   // forecast results, oldest first
  rx_req_t     pend_q[$];           // byte requests not yet handed to the driver

  int unsigned bytes_taken   = 0;
  int unsigned bytes_pushed  = 0;
  int unsigned results_seen  = 0;
  int unsigned empty_seen    = 0;
  int unsigned frames_closed = 0;
  int unsigned limits_set    = 0;
  int unsigned errors        = 0;

  function automatic bit is_dig(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // Advance the forecast model by one accepted byte. Discarded bytes leave
  // everything untouched.
  task parse_byte(input logic [7:0] c, input logic drop);
    ipd_result_t r;
    if (!drop) begin
      case (ph)
        PhHeader: begin
          // all four header bytes are eaten even after a mismatch
          if (hdr_cnt < 3'd4 && c != IpdText[hdr_cnt[1:0]]) hdr_ok = 1'b0;
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt >= 3'd4) begin
            if (hdr_ok) begin
              ph = PhLink;
              link_acc = 8'd0;
            end else begin
              ph = PhIdle;
            end
          end
        end
        PhLink: begin
          if (c == ChComma) begin
            ph = PhLength;
            len_acc = 16'd0;
          end else if (is_dig(c)) begin
            link_acc = link_acc * 8'd10 + (c - ChZero);   // wraps mod 256
          end else begin
            ph = PhIdle;   // abort; byte is not rescanned for '+'
          end
        end
        PhLength: begin
          if (c == ChColon) begin
            ph = PhData;
            pay_cnt = 16'd0;
            if (len_acc > limit_reg) len_acc = limit_reg;
          end else if (is_dig(c)) begin
            len_acc = len_acc * 16'd10 + 16'(c - ChZero);   // wraps mod 65536
          end else begin
            ph = PhIdle;
          end
        end
        PhData: begin
          r.link_number  = link_acc;
          r.frame_length = len_acc;
          if (len_acc == 16'd0) begin
            // empty frame eats one byte and posts a single notice
            r.payload_byte = 8'd0;
            r.empty_frame  = 1'b1;
            r.last         = 1'b1;
            ph = PhIdle;
          end else begin
            r.payload_byte = c;
            r.empty_frame  = 1'b0;
            pay_cnt = pay_cnt + 16'd1;
            r.last = (pay_cnt >= len_acc);
            if (r.last) ph = PhIdle;
          end
          frame_expect_q.push_back(r);
        end
        default: begin
          ph = PhIdle;
          if (c == ChPlus) begin
            ph = PhHeader;
            hdr_cnt = 3'd0;
            hdr_ok = 1'b1;
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: pops requests from pend_q, random gap after each one,
  // with calm stretches where it never idles.
  // --------------------------------------------------------------------------
  int      rx_wait = 0;
  bit      rx_calm = 1'b0;
  rx_req_t rx_next;

  initial begin
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'd0;
    rx_bus.discard = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.payload_limit = 16'd0;
    frame_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_bus.valid <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rx_bus.valid && rx_bus.ready) begin
        parse_byte(rx_bus.rx_byte, rx_bus.discard);
        bytes_taken++;
      end
      // load a new request only when none is held
      if (!rx_bus.valid || rx_bus.ready) begin
        if (rx_wait > 0) begin
          rx_wait--;
          rx_bus.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          rx_next = pend_q.pop_front();
          rx_bus.rx_byte <= rx_next.b;
          rx_bus.discard <= rx_next.d;
          rx_bus.valid   <= 1'b1;
          if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
          rx_wait = rx_calm ? 0 : int'($urandom_range(0, 12));
        end else begin
          rx_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random backpressure after each result, field-by-field
  // compare against the oldest forecast.
  // --------------------------------------------------------------------------
  int          out_wait = 0;
  bit          out_calm = 1'b0;
  ipd_result_t got;
  ipd_result_t want;

  task check_result();
    got = '{payload_byte: frame_bus.payload_byte, link_number: frame_bus.link_number,
            frame_length: frame_bus.frame_length, empty_frame: frame_bus.empty_frame,
            last: frame_bus.last};
    results_seen++;
    if (got.empty_frame) empty_seen++;
    if (got.last) frames_closed++;
    if (frame_expect_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: byte %02h link %0d len %0d empty %0b last %0b",
                 got.payload_byte, got.link_number, got.frame_length,
                 got.empty_frame, got.last);
    end else begin
      want = frame_expect_q.pop_front();
      if (got.payload_byte != want.payload_byte || got.link_number != want.link_number ||
          got.frame_length != want.frame_length || got.empty_frame != want.empty_frame ||
          got.last != want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected: byte %02h link %0d len %0d empty %0b last %0b",
                   want.payload_byte, want.link_number, want.frame_length,
                   want.empty_frame, want.last);
          $display("  actual:   byte %02h link %0d len %0d empty %0b last %0b",
                   got.payload_byte, got.link_number, got.frame_length,
                   got.empty_frame, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_bus.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        check_result();
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : int'($urandom_range(0, 12));
      end
      if (out_wait > 0) begin
        out_wait--;
        frame_bus.ready <= 1'b0;
      end else begin
        frame_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------
  task push_raw(input logic [7:0] b, input logic d);
    pend_q.push_back('{b: b, d: d});
    bytes_pushed++;
  endtask

  // every so often a dropped byte (random content, '+' included) slips in
  task push_rx(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) push_raw(8'($urandom_range(0, 255)), 1'b1);
    push_raw(b, 1'b0);
  endtask

  task automatic push_number(input int unsigned v);
    int unsigned digs[$];
    int unsigned t;
    t = v;
    do begin
      digs.push_front(t % 10);
      t = t / 10;
    end while (t != 0);
    foreach (digs[i]) push_rx(ChZero + 8'(digs[i]));
  endtask

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_dig(b) || b == ChComma || b == ChColon);
    return b;
  endfunction

  // Build one "+IPD,<link>,<len>:<payload>" frame, optionally broken.
  task automatic push_frame(input int unsigned link, input int unsigned len,
                            input frame_flaw_e flaw);
    int unsigned bad;
    int unsigned n;
    logic [7:0]  w;
    bad = $urandom_range(0, 3);
    push_rx(ChPlus);
    for (int i = 0; i < 4; i++) begin
      if (flaw == FlawHeader && i == bad) begin
        do w = 8'($urandom_range(0, 255));
        while (w == IpdText[i]);
        push_rx(w);
      end else begin
        push_rx(IpdText[i]);
      end
    end
    if (flaw == FlawHeader) return;
    if ($urandom_range(0, 9) == 0) push_rx(ChZero);   // leading zero
    push_number(link);
    if (flaw == FlawLink) begin
      push_rx(rand_nondigit());
      return;
    end
    push_rx(ChComma);
    if ($urandom_range(0, 9) == 0) push_rx(ChZero);
    push_number(len);
    if (flaw == FlawLength) begin
      push_rx(rand_nondigit());
      return;
    end
    push_rx(ChColon);
    // payload size the parser will expect: wrapped, then clamped
    n = len % 65536;
    if (n > limit_reg) n = limit_reg;
    if (n == 0) n = 1;                 // empty frame still eats one byte
    if (flaw == FlawShort && n > 1) n = $urandom_range(1, n - 1);
    repeat (n) push_rx(8'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 65) return $urandom_range(1, 8);
    if (r < 80) return $urandom_range(9, 30);
    if (r < 88) return 65536 * $urandom_range(1, 2) + $urandom_range(0, 8);  // wraps
    if (r < 94) return (limit_reg <= 40) ? $urandom_range(41, 99999) : $urandom_range(1, 8);
    return (limit_reg <= 40) ? limit_reg + $urandom_range(0, 1) : $urandom_range(1, 8);
  endfunction

  // Wait until every pushed request has been accepted and the forecast
  // parser sits idle (closing any open frame with filler), then until all
  // results are in and the block has had time to settle.
  task settle();
    while (bytes_taken != bytes_pushed) @(posedge clk);
    while (ph != PhIdle) begin
      push_raw(Filler, 1'b0);
      while (bytes_taken != bytes_pushed) @(posedge clk);
    end
    while (frame_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_limit(input logic [15:0] v);
    settle();
    @(posedge clk);
    cfg_bus.payload_limit <= v;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_bus.ready);
    limit_reg = v;
    limits_set++;
    cfg_bus.valid <= 1'b0;
  endtask

  // Random phase: mostly well-formed frames, plus noise and broken frames.
  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    int unsigned link;
    stop_at = bytes_pushed + budget;
    while (bytes_pushed < stop_at) begin
      r = $urandom_range(0, 99);
      link = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 9);
      if (r < 70) begin
        push_frame(link, pick_length(), FlawNone);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6))
          push_rx(($urandom_range(0, 3) == 0) ? ChPlus : 8'($urandom_range(0, 255)));
      end else begin
        push_frame(link, pick_length(),
                   frame_flaw_e'($urandom_range(FlawHeader, FlawShort)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    ph        = PhIdle;
    hdr_cnt   = 3'd0;
    hdr_ok    = 1'b1;
    link_acc  = 8'd0;
    len_acc   = 16'd0;
    pay_cnt   = 16'd0;
    limit_reg = LimitReset;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: link 255, payload bytes at both extremes, a dropped '+'
    // inside the header, then a zero-length frame.
    push_raw(ChPlus, 1'b0);
    push_raw(8'h49, 1'b0);
    push_raw(ChPlus, 1'b1);
    push_raw(8'h50, 1'b0);
    push_raw(8'h44, 1'b0);
    push_raw(ChComma, 1'b0);
    push_raw(8'h32, 1'b0);
    push_raw(8'h35, 1'b0);
    push_raw(8'h35, 1'b0);
    push_raw(ChComma, 1'b0);
    push_raw(8'h32, 1'b0);
    push_raw(ChColon, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(ChPlus, 1'b0);
    push_raw(8'h49, 1'b0);
    push_raw(8'h50, 1'b0);
    push_raw(8'h44, 1'b0);
    push_raw(ChComma, 1'b0);
    push_raw(ChZero, 1'b0);
    push_raw(ChComma, 1'b0);
    push_raw(ChZero, 1'b0);
    push_raw(ChColon, 1'b0);
    push_raw(8'hA5, 1'b0);

    // Random phases at the reset limit and then across several settings;
    // limit 0 turns every frame into an empty one.
    run_phase(220);
    set_limit(16'd0);
    run_phase(220);
    set_limit(16'd5);
    run_phase(220);
    set_limit(16'hFFFF);
    run_phase(220);
    set_limit(16'($urandom_range(1, 20)));
    run_phase(220);
    set_limit(LimitReset);
    run_phase(220);

    settle();
    repeat (8) @(posedge clk);

    $display("run covered %0d bytes in, %0d results out (%0d frames closed, %0d empty)",
             bytes_taken, results_seen, frames_closed, empty_seen);
    $display("payload limit written %0d times, %0d mismatches", limits_set, errors);
    if (errors == 0 && frame_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: well past the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", frame_expect_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> ipd_frame_parser.f
rtl/ipd_pkg.sv
rtl/ipd_if.sv
rtl/ipd_parse_core.sv
rtl/ipd_out_skid.sv
rtl/ipd_frame_parser.sv
tb/testbench.sv
